// ----- design/gmps_pkg.sv -----
package gmps_pkg;

   // Store dimensions.
   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int IDX_W = $clog2(CELLS);
   localparam int SP_W  = $clog2(CELLS + 1);

   // Width used for every grid-limit comparison; holds any MAX_ROWS/MAX_COLS up to 256.
   localparam int LIM_W = 9;

   // Field widths of the interfaces.
   localparam int CFG_DIM_W  = 7;
   localparam int CFG_POS_W  = 6;
   localparam int CELL_POS_W = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // Register reset values.
   localparam logic [CFG_DIM_W-1:0] NUM_ROWS_RESET = 7'd10;
   localparam logic [CFG_DIM_W-1:0] NUM_COLS_RESET = 7'd10;

   typedef enum logic [2:0] {
      REG_NUM_ROWS  = 3'd0,
      REG_NUM_COLS  = 3'd1,
      REG_START_ROW = 3'd2,
      REG_START_COL = 3'd3,
      REG_GOAL_ROW  = 3'd4,
      REG_GOAL_COL  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      DIR_SOUTH = 2'd0,
      DIR_WEST  = 2'd1,
      DIR_NORTH = 2'd2,
      DIR_EAST  = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PUSH_START,
      ST_POP,
      ST_CURRENT,
      ST_NBR_READ,
      ST_NBR_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } cell_type;

   typedef struct packed {
      cell_type pos;
      logic     in_grid;
   } nbr_type;

   // Linear store address of a cell.
   function automatic logic [IDX_W-1:0] cell_addr(input cell_type c);
      cell_addr = IDX_W'(IDX_W'(c.row) * IDX_W'(MAX_COLS) + IDX_W'(c.col));
   endfunction

endpackage

// ----- design/gmps_ram.sv -----
module gmps_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/gmps_nbr_unit.sv -----
module gmps_nbr_unit (
   input  gmps_pkg::cell_type              cur,
   input  gmps_pkg::dir_type               dir,
   input  logic [gmps_pkg::LIM_W-1:0]      rows_lim,
   input  logic [gmps_pkg::LIM_W-1:0]      cols_lim,
   output gmps_pkg::nbr_type               nbr
);
   import gmps_pkg::*;

   // One shared step/bounds unit: the current cell moved one place in the chosen direction.
   always_comb begin
      nbr.pos     = cur;
      nbr.in_grid = 1'b0;
      unique case (dir)
         DIR_SOUTH: begin
            nbr.pos.row = cur.row + ROW_W'(1);
            nbr.in_grid = (LIM_W'(cur.row) + LIM_W'(1)) < rows_lim;
         end
         DIR_WEST: begin
            nbr.pos.col = cur.col - COL_W'(1);
            nbr.in_grid = cur.col != '0;
         end
         DIR_NORTH: begin
            nbr.pos.row = cur.row - ROW_W'(1);
            nbr.in_grid = cur.row != '0;
         end
         DIR_EAST: begin
            nbr.pos.col = cur.col + COL_W'(1);
            nbr.in_grid = (LIM_W'(cur.col) + LIM_W'(1)) < cols_lim;
         end
         default: begin
            nbr.in_grid = 1'b0;
         end
      endcase
   end

endmodule

// ----- design/grid_maze_path_search.sv -----
// Grid maze path search. Maze cells arrive on the req_ stream one per transaction and are
// written into the open-cell store, so loading runs at one cell per clock while the block
// is idle. The transaction with tlast set stores its cell and then starts a depth-first
// search from the configured start cell; the block drops req_tready until the search ends
// and returns one rsp_ transaction whose bit 0 tells whether the goal cell was reached.
// The search first clears the visited marks of the grid in use, one cell per cycle
// (all cells of the grid after clamping to the store size, skipped when the start lies
// outside the grid), then pushes the start cell. Each popped cell takes a stack read and
// a goal test, and each of its four neighbours is stepped past when it falls outside the
// grid, or else takes a read of the open and visited stores, then a test and push. All
// neighbours go through one shared step-and-bounds unit, and every store is a single-port
// memory with a registered read. Registers are written through the csr_ port at byte
// addresses 0 (num_rows), 4 (num_cols), 8 (start_row), 12 (start_col), 16 (goal_row) and
// 20 (goal_col), and must only be written while no search is running.
module grid_maze_path_search (
   input  logic                                clock,
   input  logic                                reset,
   // Load stream. tdata: cell_row [5:0], cell_col [11:6], cell_open [12], zero [15:13].
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gmps_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   // Result stream. tdata: path_found [0], zero [7:1].
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gmps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Register port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gmps_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [gmps_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gmps_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import gmps_pkg::*;

   // Configuration registers.
   logic [CFG_DIM_W-1:0] num_rows_ff, num_rows_in;
   logic [CFG_DIM_W-1:0] num_cols_ff, num_cols_in;
   logic [CFG_POS_W-1:0] start_row_ff, start_row_in;
   logic [CFG_POS_W-1:0] start_col_ff, start_col_in;
   logic [CFG_POS_W-1:0] goal_row_ff, goal_row_in;
   logic [CFG_POS_W-1:0] goal_col_ff, goal_col_in;

   // Sequencer and datapath registers.
   state_type        state_ff, state_in;
   cell_type         clr_ff, clr_in;
   cell_type         cur_ff, cur_in;
   dir_type          dir_ff, dir_in;
   logic [SP_W-1:0]  sp_ff, sp_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;

   // Memory ports.
   logic [IDX_W-1:0] open_addr, vis_addr, stk_addr;
   logic             open_we, vis_we, stk_we;
   logic             open_wdata, vis_wdata;
   logic             open_rdata, vis_rdata;
   cell_type         stk_wdata, stk_rdata;

   // Decoded input fields.
   cell_type         load_cell;
   logic             load_open;
   logic             load_inside;
   logic             req_fire;

   logic             csr_write;
   reg_index_type    csr_index;

   logic [LIM_W-1:0] rows_lim, cols_lim;
   logic             start_ok;
   cell_type         start_cell;
   logic             clr_last;
   logic             goal_hit;
   logic             push_ok;
   logic             slot_free;
   nbr_type          nbr;

   //------------------------------------------------------------------
   // Register port: pready is tied high, so the access cycle always completes.
   //------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      num_rows_in  = num_rows_ff;
      num_cols_in  = num_cols_ff;
      start_row_in = start_row_ff;
      start_col_in = start_col_ff;
      goal_row_in  = goal_row_ff;
      goal_col_in  = goal_col_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_NUM_ROWS:  num_rows_in  = csr_pwdata[CFG_DIM_W-1:0];
            REG_NUM_COLS:  num_cols_in  = csr_pwdata[CFG_DIM_W-1:0];
            REG_START_ROW: start_row_in = csr_pwdata[CFG_POS_W-1:0];
            REG_START_COL: start_col_in = csr_pwdata[CFG_POS_W-1:0];
            REG_GOAL_ROW:  goal_row_in  = csr_pwdata[CFG_POS_W-1:0];
            REG_GOAL_COL:  goal_col_in  = csr_pwdata[CFG_POS_W-1:0];
            default: begin
               // Addresses past the last register are ignored.
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_NUM_ROWS:  csr_prdata = CSR_DATA_W'(num_rows_ff);
         REG_NUM_COLS:  csr_prdata = CSR_DATA_W'(num_cols_ff);
         REG_START_ROW: csr_prdata = CSR_DATA_W'(start_row_ff);
         REG_START_COL: csr_prdata = CSR_DATA_W'(start_col_ff);
         REG_GOAL_ROW:  csr_prdata = CSR_DATA_W'(goal_row_ff);
         REG_GOAL_COL:  csr_prdata = CSR_DATA_W'(goal_col_ff);
         default:       csr_prdata = '0;
      endcase
   end

   //------------------------------------------------------------------
   // Grid limits. Sizes beyond the store are clamped; a start outside the
   // grid ends the search at once with no path.
   //------------------------------------------------------------------
   assign rows_lim = (LIM_W'(num_rows_ff) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                              : LIM_W'(num_rows_ff);
   assign cols_lim = (LIM_W'(num_cols_ff) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                              : LIM_W'(num_cols_ff);
   assign start_ok = (LIM_W'(start_row_ff) < rows_lim) && (LIM_W'(start_col_ff) < cols_lim);
   assign start_cell.row = ROW_W'(start_row_ff);
   assign start_cell.col = COL_W'(start_col_ff);

   // The clearing sweep ends on the last cell of the grid in use.
   assign clr_last = ((LIM_W'(clr_ff.row) + LIM_W'(1)) == rows_lim) &&
                     ((LIM_W'(clr_ff.col) + LIM_W'(1)) == cols_lim);

   // The popped cell is on the stack read port during ST_CURRENT.
   assign goal_hit = (LIM_W'(stk_rdata.row) == LIM_W'(goal_row_ff)) &&
                     (LIM_W'(stk_rdata.col) == LIM_W'(goal_col_ff));

   // Open and visited marks of the neighbour are valid during ST_NBR_CHECK.
   assign push_ok = open_rdata & ~vis_rdata;

   assign slot_free = ~rsp_valid_ff | rsp_tready;

   //------------------------------------------------------------------
   // Input stream decode.
   //------------------------------------------------------------------
   assign req_fire      = req_tvalid & req_tready;
   assign load_cell.row = ROW_W'(req_tdata[CELL_POS_W-1:0]);
   assign load_cell.col = COL_W'(req_tdata[2*CELL_POS_W-1:CELL_POS_W]);
   assign load_open     = req_tdata[2*CELL_POS_W];
   assign load_inside   = (LIM_W'(req_tdata[CELL_POS_W-1:0]) < LIM_W'(MAX_ROWS)) &&
                          (LIM_W'(req_tdata[2*CELL_POS_W-1:CELL_POS_W]) < LIM_W'(MAX_COLS));

   //------------------------------------------------------------------
   // Shared neighbour unit.
   //------------------------------------------------------------------
   gmps_nbr_unit u_nbr (
      .cur      (cur_ff),
      .dir      (dir_ff),
      .rows_lim (rows_lim),
      .cols_lim (cols_lim),
      .nbr      (nbr)
   );

   //------------------------------------------------------------------
   // Stores.
   //------------------------------------------------------------------
   gmps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_open_ram (
      .clock   (clock),
      .addr    (open_addr),
      .wr_en   (open_we),
      .wr_data (open_wdata),
      .rd_data (open_rdata)
   );

   gmps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited_ram (
      .clock   (clock),
      .addr    (vis_addr),
      .wr_en   (vis_we),
      .wr_data (vis_wdata),
      .rd_data (vis_rdata)
   );

   gmps_ram #(.WIDTH($bits(cell_type)), .DEPTH(CELLS)) u_stack_ram (
      .clock   (clock),
      .addr    (stk_addr),
      .wr_en   (stk_we),
      .wr_data (stk_wdata),
      .rd_data (stk_rdata)
   );

   //------------------------------------------------------------------
   // Sequencer: next state.
   //------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tlast) begin
               state_in = start_ok ? ST_CLEAR : ST_FINISH;
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_PUSH_START;
            end
         end
         ST_PUSH_START: state_in = ST_POP;
         ST_POP:        state_in = (sp_ff == '0) ? ST_FINISH : ST_CURRENT;
         ST_CURRENT:    state_in = goal_hit ? ST_FINISH : ST_NBR_READ;
         ST_NBR_READ: begin
            if (nbr.in_grid) begin
               state_in = ST_NBR_CHECK;
            end else if (dir_ff == DIR_EAST) begin
               state_in = ST_POP;
            end
         end
         ST_NBR_CHECK:  state_in = (dir_ff == DIR_EAST) ? ST_POP : ST_NBR_READ;
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   //------------------------------------------------------------------
   // Sequencer: memory controls and handshake.
   //------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      open_addr  = cell_addr(nbr.pos);
      open_we    = 1'b0;
      open_wdata = load_open;
      vis_addr   = cell_addr(nbr.pos);
      vis_we     = 1'b0;
      vis_wdata  = 1'b1;
      stk_addr   = sp_ff[IDX_W-1:0];
      stk_we     = 1'b0;
      stk_wdata  = nbr.pos;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            open_addr  = cell_addr(load_cell);
            open_we    = req_fire & load_inside;
         end
         ST_CLEAR: begin
            vis_addr  = cell_addr(clr_ff);
            vis_we    = 1'b1;
            vis_wdata = 1'b0;
         end
         ST_PUSH_START: begin
            vis_addr  = cell_addr(start_cell);
            vis_we    = 1'b1;
            stk_addr  = '0;
            stk_we    = 1'b1;
            stk_wdata = start_cell;
         end
         ST_POP: begin
            stk_addr = IDX_W'(sp_ff - SP_W'(1));
         end
         ST_NBR_CHECK: begin
            vis_we = push_ok;
            stk_we = push_ok;
         end
         ST_CURRENT, ST_NBR_READ, ST_FINISH: begin
            // Reads only, addressed by the defaults.
         end
         default: begin
         end
      endcase
   end

   //------------------------------------------------------------------
   // Datapath register updates.
   //------------------------------------------------------------------
   always_comb begin
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      dir_in       = dir_ff;
      sp_in        = sp_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_found_in = rsp_found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            clr_in   = '0;
            sp_in    = '0;
            found_in = 1'b0;
         end
         ST_CLEAR: begin
            if ((LIM_W'(clr_ff.col) + LIM_W'(1)) == cols_lim) begin
               clr_in.col = '0;
               clr_in.row = clr_ff.row + ROW_W'(1);
            end else begin
               clr_in.col = clr_ff.col + COL_W'(1);
            end
         end
         ST_PUSH_START: sp_in = SP_W'(1);
         ST_POP: begin
            if (sp_ff != '0) begin
               sp_in = sp_ff - SP_W'(1);
            end
         end
         ST_CURRENT: begin
            cur_in = stk_rdata;
            dir_in = DIR_SOUTH;
            if (goal_hit) begin
               found_in = 1'b1;
            end
         end
         ST_NBR_READ: begin
            if (!nbr.in_grid) begin
               dir_in = dir_type'(dir_ff + 2'd1);
            end
         end
         ST_NBR_CHECK: begin
            dir_in = dir_type'(dir_ff + 2'd1);
            if (push_ok) begin
               sp_in = sp_ff + SP_W'(1);
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
         num_rows_ff  <= NUM_ROWS_RESET;
         num_cols_ff  <= NUM_COLS_RESET;
         start_row_ff <= '0;
         start_col_ff <= '0;
         goal_row_ff  <= '0;
         goal_col_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
         num_rows_ff  <= num_rows_in;
         num_cols_ff  <= num_cols_in;
         start_row_ff <= start_row_in;
         start_col_ff <= start_col_in;
         goal_row_ff  <= goal_row_in;
         goal_col_ff  <= goal_col_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff       <= clr_in;
      cur_ff       <= cur_in;
      dir_ff       <= dir_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-1)'(0), rsp_found_ff};

   //------------------------------------------------------------------
   // Assertions.
   //------------------------------------------------------------------
`ifndef SYNTHESIS
   // A result only appears once a search has finished.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish step");

   // Every neighbour that is tested against the stores lies inside the grid.
   a_nbr_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NBR_CHECK) |-> nbr.in_grid)
      else $error("neighbour test outside the grid");

   // The cell being expanded always lies inside the grid in use.
   a_cur_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NBR_READ) |->
         ((LIM_W'(cur_ff.row) < rows_lim) && (LIM_W'(cur_ff.col) < cols_lim)))
      else $error("expanded cell outside the grid");

   // Each cell is pushed at most once, so the stack never holds more than the store.
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NBR_CHECK) && push_ok |-> (sp_ff < SP_W'(CELLS)))
      else $error("stack overflow");
`endif

endmodule

// ----- test/grid_maze_path_search_test.sv -----
// Testbench for grid_maze_path_search.
//
// Stimulus comes from the main initial block, which fills a queue of maze cell loads. A
// clocked driver feeds that queue onto the req_ stream. A clocked monitor watches both
// streams. Every accepted load transaction updates a local copy of the maze. A load that
// carries tlast also runs a local depth-first search and queues the expected path_found
// bit, which the next rsp_ transaction must match.
//
// The search reads maze cells inside the configured grid. Cells that were never loaded
// are undefined in the block, so the generator tracks every cell it has queued. It only
// asks for a search once every cell of the grid in use has been loaded at least once.
module grid_maze_path_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gmps_pkg::*;

   // Rough number of load transactions; decides when the random part stops and when the idle regimes change.
   localparam int TOTAL_ITEMS = 1250;
   // Length of the long receiver hold-off.
   localparam int HOLD_LEN    = 500;
   // Quiet cycles after the last result.
   localparam int TAIL_CYCLES = 50;

   // One maze cell load, as queued for the driver.
   typedef struct packed {
      logic                  last;
      logic                  open;
      logic [CELL_POS_W-1:0] col;
      logic [CELL_POS_W-1:0] row;
   } cell_load_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata: cell_row [5:0], cell_col [11:6], cell_open [12], zero [15:13].
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: path_found [0], zero [7:1].
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   grid_maze_path_search dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Local copy of the registers and of the maze, kept in step with the block.
   logic [CFG_DIM_W-1:0] rows_cfg = NUM_ROWS_RESET;
   logic [CFG_DIM_W-1:0] cols_cfg = NUM_COLS_RESET;
   logic [CFG_POS_W-1:0] start_row_cfg = '0;
   logic [CFG_POS_W-1:0] start_col_cfg = '0;
   logic [CFG_POS_W-1:0] goal_row_cfg = '0;
   logic [CFG_POS_W-1:0] goal_col_cfg = '0;
   bit                   open_store [CELLS];

   // Generator side: cells already queued at least once, and pending loads.
   bit                   cell_queued [CELLS];
   cell_load_type        load_queue [$];
   int                   items_queued = 0;

   // Checking side.
   bit                   expected_paths [$];
   int                   accepted_items = 0;
   int                   mismatch_count = 0;
   bit                   want_found;
   int                   load_index;
   cell_load_type        driver_cell;

   // Receiver hold-off state.
   bit                   hold_active = 1'b0;
   bit                   hold_done = 1'b0;
   int                   hold_cycles = 0;

   // Grid size in use after the clamp to the store size.
   function automatic int grid_rows();
      return (int'(rows_cfg) > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
   endfunction

   function automatic int grid_cols();
      return (int'(cols_cfg) > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
   endfunction

   // Depth-first search over the local maze copy. The start cell is searched from even
   // when it is a wall, since only neighbors are tested for being open. A start outside
   // the grid finds nothing. A goal outside the grid is never reached.
   function automatic bit goal_reachable();
      int  rows, cols, depth, idx, r, c, nr, nc, nidx;
      bit  in_grid;
      bit  seen [CELLS];
      int  pending [CELLS];
      rows = grid_rows();
      cols = grid_cols();
      if (int'(start_row_cfg) >= rows || int'(start_col_cfg) >= cols)
         return 1'b0;
      foreach (seen[i])
         seen[i] = 1'b0;
      idx = int'(start_row_cfg) * MAX_COLS + int'(start_col_cfg);
      seen[idx] = 1'b1;
      pending[0] = idx;
      depth = 1;
      while (depth > 0) begin
         depth--;
         idx = pending[depth];
         r = idx / MAX_COLS;
         c = idx % MAX_COLS;
         if (r == int'(goal_row_cfg) && c == int'(goal_col_cfg))
            return 1'b1;
         for (int d = 0; d < 4; d++) begin
            nr = r;
            nc = c;
            case (dir_type'(d))
               DIR_SOUTH: begin
                  nr = r + 1;
                  in_grid = nr < rows;
               end
               DIR_WEST: begin
                  nc = c - 1;
                  in_grid = c > 0;
               end
               DIR_NORTH: begin
                  nr = r - 1;
                  in_grid = r > 0;
               end
               default: begin
                  nc = c + 1;
                  in_grid = nc < cols;
               end
            endcase
            if (in_grid) begin
               nidx = nr * MAX_COLS + nc;
               if (open_store[nidx] && !seen[nidx]) begin
                  seen[nidx] = 1'b1;
                  pending[depth] = nidx;
                  depth++;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   // True once every cell of the grid in use has been queued at least once.
   function automatic bit grid_loaded();
      for (int r = 0; r < grid_rows(); r++)
         for (int c = 0; c < grid_cols(); c++)
            if (!cell_queued[r * MAX_COLS + c])
               return 1'b0;
      return 1'b1;
   endfunction

   task automatic queue_cell(input int row, input int col, input bit open, input bit last);
      cell_load_type item;
      item.row = CELL_POS_W'(row);
      item.col = CELL_POS_W'(col);
      item.open = open;
      item.last = last;
      load_queue.push_back(item);
      cell_queued[row * MAX_COLS + col] = 1'b1;
      items_queued++;
   endtask

   // One maze frame. A full frame loads every cell that was never loaded plus a random
   // half of the others, in shuffled order with a little noise at random cells of the store,
   // and closes on tlast. A short frame is a lone tlast transaction at a random cell, which
   // then searches the maze; it is only used once the grid is fully loaded or is empty.
   task automatic queue_frame();
      int cells [$];
      int density, pick, tmp;
      if (grid_rows() * grid_cols() == 0 || (grid_loaded() && $urandom_range(1) == 0)) begin
         queue_cell($urandom_range(63), $urandom_range(63), $urandom_range(1), 1'b1);
         return;
      end
      density = $urandom_range(40, 95);
      for (int r = 0; r < grid_rows(); r++)
         for (int c = 0; c < grid_cols(); c++)
            if (!cell_queued[r * MAX_COLS + c] || $urandom_range(1) == 1)
               cells.push_back(r * MAX_COLS + c);
      for (int i = cells.size() - 1; i > 0; i--) begin
         pick = $urandom_range(i);
         tmp = cells[i];
         cells[i] = cells[pick];
         cells[pick] = tmp;
      end
      if (cells.size() == 0) begin
         queue_cell($urandom_range(63), $urandom_range(63), $urandom_range(1), 1'b1);
         return;
      end
      foreach (cells[i]) begin
         if ($urandom_range(19) == 0)
            queue_cell($urandom_range(63), $urandom_range(63), $urandom_range(1), 1'b0);
         queue_cell(cells[i] / MAX_COLS, cells[i] % MAX_COLS,
                    $urandom_range(99) < density, i == cells.size() - 1);
      end
   endtask

   // Register write: a setup phase, then an access phase that completes at the first edge
   // with pready high. The local register copy follows at that edge.
   task automatic write_reg(input reg_index_type which, input int value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(which));
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (which)
         REG_NUM_ROWS:  rows_cfg = CFG_DIM_W'(value);
         REG_NUM_COLS:  cols_cfg = CFG_DIM_W'(value);
         REG_START_ROW: start_row_cfg = CFG_POS_W'(value);
         REG_START_COL: start_col_cfg = CFG_POS_W'(value);
         REG_GOAL_ROW:  goal_row_cfg = CFG_POS_W'(value);
         default:       goal_col_cfg = CFG_POS_W'(value);
      endcase
   endtask

   // Sender pause: wait until every queued load has been accepted and every result has
   // arrived, then let the block settle so that it is surely back in idle.
   task automatic drain();
      while (accepted_items != items_queued || expected_paths.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Driver. A new transaction is offered only once the previous one has been taken. The
   // idle rate steps through three regimes as the run progresses: receiver often idle, then
   // sender often idle, then neither.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (load_queue.size() != 0 &&
             $urandom_range(99) >= ((accepted_items < TOTAL_ITEMS / 3) ? 26 :
                                    (accepted_items < 2 * TOTAL_ITEMS / 3) ? 69 : 0)) begin
            driver_cell = load_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {3'b000, driver_cell.open, driver_cell.col, driver_cell.row};
            req_tlast <= driver_cell.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver. During the long hold-off it refuses every result, so the block sits on a
   // finished search and has to stall the load stream behind it.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !hold_active &&
                       $urandom_range(99) >= ((accepted_items < TOTAL_ITEMS / 3) ? 69 :
                                              (accepted_items < 2 * TOTAL_ITEMS / 3) ? 26 : 0);
   end

   // The long hold-off is timed here in its own counter. It starts the first time a result
   // is waiting while the sender offers another search, so that the second search ends
   // with nowhere to put its result.
   always @(posedge clock) begin
      if (reset) begin
         hold_active <= 1'b0;
         hold_done <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_active) begin
         if (hold_cycles == 1)
            hold_active <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && rsp_tvalid && req_tvalid && req_tlast) begin
         hold_active <= 1'b1;
         hold_done <= 1'b1;
         hold_cycles <= HOLD_LEN;
      end
   end

   // Monitor. Results are checked before the load of the same edge is applied, since a
   // result can never belong to a load accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_paths.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: result 0x%02h arrived with no search pending", rsp_tdata);
            end else begin
               want_found = expected_paths.pop_front();
               if (rsp_tdata !== {7'b0, want_found}) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: path_found expected %0d, got tdata 0x%02h",
                              want_found, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            load_index = int'(req_tdata[5:0]) * MAX_COLS + int'(req_tdata[11:6]);
            open_store[load_index] = req_tdata[12];
            if (req_tlast)
               expected_paths.push_back(goal_reachable());
            accepted_items <= accepted_items + 1;
         end
      end
   end

   // Main sequence: reset, a directed part on a tiny 2 x 3 grid and an empty grid, then random phases.
   initial begin
      int sel, rows_val, cols_val, rows_in, cols_in, sr, sc, gr, gc;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The first frame loads the whole grid, with a path around the wall
      // at (0,2), and closes on the far corner of the store.
      write_reg(REG_NUM_ROWS, 2);
      write_reg(REG_NUM_COLS, 3);
      write_reg(REG_START_ROW, 0);
      write_reg(REG_START_COL, 0);
      write_reg(REG_GOAL_ROW, 1);
      write_reg(REG_GOAL_COL, 2);
      queue_cell(0, 0, 1'b1, 1'b0);
      queue_cell(0, 1, 1'b1, 1'b0);
      queue_cell(0, 2, 1'b0, 1'b0);
      queue_cell(1, 0, 1'b1, 1'b0);
      queue_cell(1, 1, 1'b1, 1'b0);
      queue_cell(1, 2, 1'b1, 1'b0);
      queue_cell(63, 63, 1'b0, 1'b1);
      // Walling off (1,1) cuts the goal off. The repeated load behind it keeps the sender
      // offering while the block holds a finished search.
      queue_cell(1, 1, 1'b0, 1'b1);
      queue_cell(1, 1, 1'b0, 1'b0);
      drain();
      // The start is the goal and a wall: found all the same.
      write_reg(REG_START_ROW, 1);
      write_reg(REG_START_COL, 1);
      write_reg(REG_GOAL_ROW, 1);
      write_reg(REG_GOAL_COL, 1);
      queue_cell(0, 63, 1'b1, 1'b1);
      drain();
      // The start lies below the last row.
      write_reg(REG_START_ROW, 2);
      write_reg(REG_START_COL, 0);
      queue_cell(63, 0, 1'b1, 1'b1);
      drain();
      // The start is a wall but is still searched from.
      write_reg(REG_START_ROW, 0);
      write_reg(REG_START_COL, 2);
      write_reg(REG_GOAL_ROW, 0);
      write_reg(REG_GOAL_COL, 0);
      queue_cell(1, 1, 1'b1, 1'b1);
      drain();
      // The goal lies outside the grid.
      write_reg(REG_GOAL_ROW, 5);
      write_reg(REG_GOAL_COL, 5);
      queue_cell(1, 0, 1'b1, 1'b1);
      drain();
      // An empty grid finds nothing.
      write_reg(REG_NUM_ROWS, 0);
      queue_cell(0, 0, 1'b1, 1'b1);
      drain();

      // Random phases. Each picks a grid shape, mostly small, sometimes a medium grid, a
      // full-height or full-width strip, a size past the store that gets clamped, or an empty
      // grid. Then it picks start and goal cells and runs a few frames before draining.
      while (items_queued < TOTAL_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 66) begin
            rows_val = $urandom_range(1, 8);
            cols_val = $urandom_range(1, 8);
         end else if (sel < 76) begin
            rows_val = MAX_ROWS;
            cols_val = $urandom_range(1, 2);
         end else if (sel < 86) begin
            rows_val = $urandom_range(1, 2);
            cols_val = MAX_COLS;
         end else if (sel < 91) begin
            rows_val = $urandom_range(MAX_ROWS + 1, 127);
            cols_val = $urandom_range(1, 3);
         end else if (sel < 93) begin
            rows_val = $urandom_range(1, 3);
            cols_val = $urandom_range(MAX_COLS + 1, 127);
         end else if (sel < 96) begin
            if ($urandom_range(1) == 1) begin
               rows_val = 0;
               cols_val = $urandom_range(127);
            end else begin
               rows_val = $urandom_range(127);
               cols_val = 0;
            end
         end else begin
            rows_val = $urandom_range(9, 16);
            cols_val = $urandom_range(9, 16);
         end
         rows_in = (rows_val > MAX_ROWS) ? MAX_ROWS : rows_val;
         cols_in = (cols_val > MAX_COLS) ? MAX_COLS : cols_val;

         sel = $urandom_range(99);
         if (rows_in * cols_in > 0 && sel < 75) begin
            sr = $urandom_range(rows_in - 1);
            sc = $urandom_range(cols_in - 1);
         end else if (sel < 88) begin
            sr = $urandom_range(63);
            sc = $urandom_range(63);
         end else if (sel < 94) begin
            sr = 63;
            sc = 63;
         end else begin
            sr = 0;
            sc = 0;
         end

         sel = $urandom_range(99);
         if (rows_in * cols_in > 0 && sel < 55) begin
            gr = $urandom_range(rows_in - 1);
            gc = $urandom_range(cols_in - 1);
         end else if (sel < 70) begin
            gr = sr;
            gc = sc;
         end else if (rows_in * cols_in > 0 && sel < 82) begin
            gr = rows_in - 1;
            gc = cols_in - 1;
         end else if (sel < 92) begin
            gr = $urandom_range(63);
            gc = $urandom_range(63);
         end else begin
            gr = 63;
            gc = 0;
         end

         write_reg(REG_NUM_ROWS, rows_val);
         write_reg(REG_NUM_COLS, cols_val);
         write_reg(REG_START_ROW, sr);
         write_reg(REG_START_COL, sc);
         write_reg(REG_GOAL_ROW, gr);
         write_reg(REG_GOAL_COL, gc);
         repeat ($urandom_range(1, 4))
            if (items_queued < TOTAL_ITEMS)
               queue_frame();
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_paths.size() == 0)
         $display("[grid_maze_path_search] OK");
      else
         $display("[grid_maze_path_search] ERROR");
      $finish;
   end

   // Watchdog: 200 ms.
   initial begin
      #200_000_000;
      $display("[grid_maze_path_search] ERROR");
      $finish;
   end

endmodule
